// ----- hw/rtl/lags_pkg.sv -----
// lags_pkg: shared widths, operation codes, register indexes, FSM state type and
// the structs passed between the chain cells, the rule logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lags_pkg;

   // Field widths
   localparam int FUNC_W      = 2;
   localparam int COORD_W     = 4;
   localparam int PIXEL_W     = 8;
   localparam int BIRTHS_W    = 9;
   localparam int FIRST_ROW_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [BIRTHS_W-1:0] BIRTHS_MAX      = 9'd511;
   localparam logic [PIXEL_W-1:0]  BIRTH_LEVEL_RST = 8'd255;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ROW   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_LEVEL = 1'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_READ,
      ST_DONE
   } lags_state_type;

   // Control shared by every cell of the line buffer
   typedef struct packed {
      logic clear;
      logic shift;
   } lags_chain_ctl_type;

   // 3x3 neighborhood around the center cell
   typedef struct packed {
      logic [2:0] left;    // up-left, left, down-left
      logic [1:0] mid;     // up, down
      logic [2:0] right;   // up-right, right, down-right
      logic       center;
   } lags_window_type;

   // Decision for the center cell
   typedef struct packed {
      logic kill;
      logic birth;
   } lags_verdict_type;

endpackage

// ----- hw/rtl/lags_if.sv -----
// lags_if: valid/ready channel interfaces for request and response transfers.
// Depends on lags_pkg for field widths.
`timescale 1ns / 1ps

interface lags_req_if
   import lags_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;

   modport source(output valid, output func, output col, output row, input ready);
   modport sink(input valid, input func, input col, input row, output ready);
endinterface

interface lags_rsp_if
   import lags_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  pixel_value;
   logic [BIRTHS_W-1:0] births;

   modport source(output valid, output pixel_value, output births, input ready);
   modport sink(input valid, input pixel_value, input births, output ready);
endinterface

// ----- hw/rtl/life_automaton_grid_step_unit.sv -----
// life_automaton_grid_step_unit: Conway generation engine over a pixel frame
// and seed map. Depends on lags_pkg, lags_if, lags_cell and lags_rule.
`timescale 1ns / 1ps

// Holds a COLUMNS x ROWS frame of 8-bit pixels and a one-bit seed map in two
// on-chip memories. A seed transfer marks one cell live. A read transfer
// returns one pixel. A step transfer runs one generation on rows first_row and
// below: the frame is swept in raster order through its single read port into
// a line buffer of 2*COLUMNS+3 cells, and each cell is decided as it reaches
// the center of the 3x3 window; when the sweep ends the result is posted. The
// same sweep clears the whole seed map. One item is in work at a time; a
// finished result sits in the output register while the next item is taken.
// After reset the block clears both memories and takes no items then;
// configuration writes are taken at any time.
module life_automaton_grid_step_unit
   import lags_pkg::*;
#(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   lags_req_if.sink               req_bus,
   lags_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int CHAIN_LEN = 2 * COLUMNS + 3;
   localparam int POS_W     = $clog2(17 * COLUMNS + CELLS + 4);
   localparam logic [POS_W-1:0] CELLS_POS   = POS_W'(CELLS);
   localparam logic [POS_W-1:0] CLEAR_LAST  = POS_W'(CELLS - 1);
   localparam logic [POS_W-1:0] STEP_LAST   = POS_W'(CELLS + COLUMNS + 2);
   localparam logic [POS_W-1:0] CENTER_LAG  = POS_W'(COLUMNS + 3);
   localparam logic [POS_W-1:0] COLUMNS_POS = POS_W'(COLUMNS);
   localparam logic [POS_W-1:0] ROWS_POS    = POS_W'(ROWS);
   localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);

   // Memories
   logic [PIXEL_W-1:0] frame_mem [CELLS];
   logic               seed_mem  [CELLS];

   logic               frame_we;
   logic [ADDR_W-1:0]  frame_waddr;
   logic [PIXEL_W-1:0] frame_wdata;
   logic [ADDR_W-1:0]  frame_raddr;
   logic [PIXEL_W-1:0] frame_rdata_ff;
   logic               seed_we;
   logic [ADDR_W-1:0]  seed_waddr;
   logic               seed_wdata;
   logic               seed_rdata_ff;

   // Control and result registers
   lags_state_type      state_ff, state_in;
   logic [POS_W-1:0]    sweep_ff, sweep_in;
   logic [POS_W-1:0]    base_ff, base_in;
   logic [POS_W-1:0]    cen_addr_ff, cen_addr_in;
   logic [COL_W-1:0]    cen_col_ff, cen_col_in;
   logic [BIRTHS_W-1:0] births_ff, births_in;
   logic [PIXEL_W-1:0]  res_pixel_ff, res_pixel_in;
   logic                read_inside_ff, read_inside_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic [BIRTHS_W-1:0] rsp_births_ff, rsp_births_in;
   logic [FIRST_ROW_W-1:0] first_row_ff;
   logic [PIXEL_W-1:0]  birth_level_ff;

   // Datapath
   logic               req_fire;
   logic [POS_W-1:0]   item_pos;
   logic               item_inside;
   logic [POS_W-1:0]   step_pos;
   logic               step_rd;
   logic               cen_valid;
   logic               live_in;
   logic [CHAIN_LEN-1:0] chain_q;
   lags_chain_ctl_type chain_ctl;
   lags_window_type    window;
   lags_verdict_type   verdict;

   // Decode the addressed cell of a seed or read item
   assign item_pos    = POS_W'(req_bus.row) * COLUMNS_POS + POS_W'(req_bus.col);
   assign item_inside = POS_W'(req_bus.row) < ROWS_POS;
   assign req_fire    = req_bus.valid && req_bus.ready;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_value = rsp_pixel_ff;
   assign rsp_bus.births      = rsp_births_ff;

   // Sweep position of the cell fetched this cycle
   assign step_pos  = base_ff + sweep_ff;
   assign step_rd   = (state_ff == ST_STEP) && (step_pos < CELLS_POS);
   assign cen_valid = (state_ff == ST_STEP) && (sweep_ff >= CENTER_LAG)
                      && (cen_addr_ff < CELLS_POS);

   // A cell is live when seeded or its pixel is nonzero
   assign live_in = rd_valid_ff && (seed_rdata_ff || (frame_rdata_ff != '0));

   // Line buffer of live bits
   assign chain_ctl.clear = req_fire && (req_bus.func == FUNC_STEP);
   assign chain_ctl.shift = (state_ff == ST_STEP);

   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
      if (k == 0) begin : g_head
         lags_cell u_cell (
            .clock    (clock),
            .ctl      (chain_ctl),
            .live_in  (live_in),
            .live_out (chain_q[k])
         );
      end else begin : g_body
         lags_cell u_cell (
            .clock    (clock),
            .ctl      (chain_ctl),
            .live_in  (chain_q[k-1]),
            .live_out (chain_q[k])
         );
      end
   end

   // Window taps around the center stage
   always_comb begin
      window.center = chain_q[COLUMNS+1];
      window.left   = {chain_q[2*COLUMNS+2], chain_q[COLUMNS+2], chain_q[2]};
      window.mid    = {chain_q[2*COLUMNS+1], chain_q[1]};
      window.right  = {chain_q[2*COLUMNS], chain_q[COLUMNS], chain_q[0]};
   end

   lags_rule u_rule (
      .window   (window),
      .at_left  (cen_col_ff == '0),
      .at_right (cen_col_ff == COL_LAST),
      .verdict  (verdict)
   );

   // Frame and seed memories, registered read
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      if (seed_we) begin
         seed_mem[seed_waddr] <= seed_wdata;
      end
      frame_rdata_ff <= frame_mem[frame_raddr];
      seed_rdata_ff  <= seed_mem[frame_raddr];
   end

   // Next state, memory ports and result loading
   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      base_in        = base_ff;
      cen_addr_in    = cen_addr_ff;
      cen_col_in     = cen_col_ff;
      births_in      = births_ff;
      res_pixel_in   = res_pixel_ff;
      read_inside_in = read_inside_ff;
      rd_valid_in    = step_rd;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_births_in  = rsp_births_ff;

      frame_we    = 1'b0;
      frame_waddr = sweep_ff[ADDR_W-1:0];
      frame_wdata = '0;
      frame_raddr = step_pos[ADDR_W-1:0];
      seed_we     = 1'b0;
      seed_waddr  = sweep_ff[ADDR_W-1:0];
      seed_wdata  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            frame_we = 1'b1;
            seed_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            frame_raddr = item_pos[ADDR_W-1:0];
            if (req_fire) begin
               case (req_bus.func)
                  FUNC_SEED: begin
                     seed_we    = item_inside;
                     seed_waddr = item_pos[ADDR_W-1:0];
                     seed_wdata = 1'b1;
                  end
                  FUNC_STEP: begin
                     state_in    = ST_STEP;
                     sweep_in    = '0;
                     base_in     = POS_W'(first_row_ff) * COLUMNS_POS;
                     cen_addr_in = POS_W'(first_row_ff) * COLUMNS_POS;
                     cen_col_in  = '0;
                     births_in   = '0;
                  end
                  FUNC_READ: begin
                     state_in       = ST_READ;
                     read_inside_in = item_inside;
                     births_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STEP: begin
            // Clear the seed map behind the fetch position
            seed_we  = (sweep_ff < CELLS_POS);
            sweep_in = sweep_ff + 1'b1;
            // Write back the decided center cell
            if (cen_valid) begin
               frame_we    = verdict.kill || verdict.birth;
               frame_waddr = cen_addr_ff[ADDR_W-1:0];
               frame_wdata = verdict.birth ? birth_level_ff : '0;
               cen_addr_in = cen_addr_ff + 1'b1;
               cen_col_in  = (cen_col_ff == COL_LAST) ? '0 : cen_col_ff + 1'b1;
               if (verdict.birth && (births_ff != BIRTHS_MAX)) begin
                  births_in = births_ff + 1'b1;
               end
            end
            if (sweep_ff == STEP_LAST) begin
               state_in     = ST_DONE;
               res_pixel_in = '0;
            end
         end
         ST_READ: begin
            res_pixel_in = read_inside_ff ? frame_rdata_ff : '0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = res_pixel_ff;
               rsp_births_in = births_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      cen_addr_ff    <= cen_addr_in;
      cen_col_ff     <= cen_col_in;
      births_ff      <= births_in;
      res_pixel_ff   <= res_pixel_in;
      read_inside_ff <= read_inside_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_births_ff  <= rsp_births_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff   <= '0;
         birth_level_ff <= BIRTH_LEVEL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_ROW:   first_row_ff   <= csr_wdata[FIRST_ROW_W-1:0];
            CSR_BIRTH_LEVEL: birth_level_ff <= csr_wdata[PIXEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/lags_cell.sv -----
// lags_cell: one stage of the live-bit line buffer; takes its neighbor's bit
// every sweep cycle. Depends on lags_pkg.
`timescale 1ns / 1ps

module lags_cell
   import lags_pkg::*;
(
   input  logic               clock,
   input  lags_chain_ctl_type ctl,
   input  logic               live_in,
   output logic               live_out
);

   logic live_ff;

   // Clear at the start of a generation, then advance one stage per cycle while a step sweep runs
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         live_ff <= 1'b0;
      end else if (ctl.shift) begin
         live_ff <= live_in;
      end
   end

   assign live_out = live_ff;

endmodule

// ----- hw/rtl/lags_rule.sv -----
// lags_rule: counts live neighbors of the center cell, masking the left and right
// grid edges, and applies the survival and birth rules. Depends on lags_pkg.
`timescale 1ns / 1ps

module lags_rule
   import lags_pkg::*;
(
   input  lags_window_type  window,
   input  logic             at_left,
   input  logic             at_right,
   output lags_verdict_type verdict
);

   logic [2:0] left_live;
   logic [2:0] right_live;
   logic [3:0] count;

   // Drop neighbors that would wrap around a row end
   assign left_live  = at_left  ? 3'b000 : window.left;
   assign right_live = at_right ? 3'b000 : window.right;

   assign count = 4'(left_live[0]) + 4'(left_live[1]) + 4'(left_live[2])
                + 4'(window.mid[0]) + 4'(window.mid[1])
                + 4'(right_live[0]) + 4'(right_live[1]) + 4'(right_live[2]);

   // Underpopulation or overcrowding kills, exactly three gives a birth
   always_comb begin
      verdict.kill  = window.center && ((count < 4'd2) || (count > 4'd3));
      verdict.birth = !window.center && (count == 4'd3);
   end

endmodule
